### src/framed_message_ring_receiver_defines.svh
// Assertion macros used by the top-level file to check this block.
`ifndef FRAMED_MESSAGE_RING_RECEIVER_DEFINES_SVH
`define FRAMED_MESSAGE_RING_RECEIVER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FMRR_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define FMRR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### src/fmrr_pkg.sv
package fmrr_pkg;

    localparam int RING_DEPTH  = 64;
    localparam int ADDR_W      = $clog2(RING_DEPTH);
    localparam int CNT_W       = (ADDR_W + 1 > 7) ? ADDR_W + 1 : 7;
    localparam int MAX_RESULTS = 63;
    localparam int CFG_IDX_W   = 2;

    localparam logic [7:0] CR_BYTE     = 8'h0D;
    localparam logic [7:0] START_RESET = 8'd254;
    localparam logic [6:0] LIMIT_RESET = 7'd64;

    localparam logic [CFG_IDX_W-1:0] REG_START_BYTE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_LIMIT  = 2'd1;

    typedef logic [ADDR_W-1:0] ptr_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    typedef enum logic [1:0] {
        ST_DATA     = 2'd0,
        ST_DROPPED  = 2'd1,
        ST_OVERFLOW = 2'd2,
        ST_EMPTY    = 2'd3
    } status_t;

    typedef enum logic {
        OP_BYTE = 1'b0,
        OP_PULL = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TYPE_RD,
        S_TYPE_CHK,
        S_SCAN,
        S_EMIT,
        S_FLUSH
    } state_t;

    typedef struct packed {
        logic    load_want;
        logic    set_fs;
        logic    write_byte;
        logic    set_in_frame;
        logic    clr_in_frame;
        logic    ptr_type;
        logic    scan_init;
        logic    scan_step;
        logic    match_setup;
        logic    pull_setup;
        logic    emit_step;
        logic    emit_status;
        status_t status_code;
    } dp_cmd_t;

    typedef struct packed {
        logic in_frame;
        logic is_start;
        logic is_cr;
        logic full;
        logic type_match;
        logic match_zero;
        logic found;
        logic exhausted;
        logic pull_zero;
        logic emit_final;
    } dp_stat_t;

    function automatic ptr_t ring_next(ptr_t i);
        return (i == ptr_t'(RING_DEPTH - 1)) ? '0 : i + ptr_t'(1);
    endfunction

endpackage

### src/fmrr_datapath.sv
module fmrr_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  fmrr_pkg::dp_cmd_t              cmd,
    output fmrr_pkg::dp_stat_t             stat,
    input  logic [7:0]                     in_byte,
    input  logic [7:0]                     wanted_type,
    input  logic                           cfg_write,
    input  logic [fmrr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                     cfg_data,
    output logic                           result_strobe,
    output logic [7:0]                     out_byte,
    output logic                           last,
    output logic [1:0]                     status
);
    import fmrr_pkg::*;

    logic [7:0] ring_mem [RING_DEPTH];
    logic [7:0] rd_data_reg;

    ptr_t       head_reg, head_next;
    ptr_t       tail_reg, tail_next;
    ptr_t       fs_reg, fs_next;
    ptr_t       ptr_reg, ptr_next;
    logic       in_frame_reg, in_frame_next;
    logic [7:0] start_byte_reg, start_byte_next;
    logic [6:0] out_limit_reg, out_limit_next;
    logic [7:0] want_reg, want_next;
    cnt_t       cnt_reg, cnt_next;
    cnt_t       len_reg, len_next;
    logic       chk_valid_reg, chk_valid_next;
    logic       pend_reg, pend_next;
    logic       pend_last_reg, pend_last_next;
    logic       strobe_reg, strobe_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic       last_reg, last_next;
    status_t    status_reg, status_next;

    ptr_t       tail_inc;
    logic [6:0] cap_lim;
    cnt_t       cap;
    cnt_t       frame_len;
    cnt_t       body_len;
    cnt_t       match_cnt;
    cnt_t       pull_len;
    cnt_t       pull_cnt;

    always_ff @(posedge clk)
    begin
        if (cmd.write_byte)
        begin
            ring_mem[tail_reg] <= in_byte;
        end
        rd_data_reg <= ring_mem[ptr_reg];
    end

    always_comb
    begin
        tail_inc  = ring_next(tail_reg);
        cap_lim   = (out_limit_reg == 7'd0) ? 7'd0 : out_limit_reg - 7'd1;
        cap       = (cap_lim > 7'(MAX_RESULTS)) ? CNT_W'(MAX_RESULTS) : CNT_W'(cap_lim);
        frame_len = (tail_reg >= fs_reg) ? CNT_W'(tail_reg) - CNT_W'(fs_reg)
                                         : CNT_W'(tail_reg) + CNT_W'(RING_DEPTH) - CNT_W'(fs_reg);
        body_len  = frame_len - CNT_W'(2);
        match_cnt = (body_len < cap) ? body_len : cap;
        pull_len  = len_reg + CNT_W'(1);
        pull_cnt  = (pull_len < cap) ? pull_len : cap;
    end

    always_comb
    begin
        stat.in_frame   = in_frame_reg;
        stat.is_start   = (in_byte == start_byte_reg);
        stat.is_cr      = (in_byte == CR_BYTE);
        stat.full       = (tail_inc == head_reg);
        stat.type_match = (rd_data_reg == want_reg);
        stat.match_zero = (match_cnt == '0);
        stat.found      = chk_valid_reg && (rd_data_reg == CR_BYTE);
        stat.exhausted  = !chk_valid_reg && (ptr_reg == tail_reg);
        stat.pull_zero  = (pull_cnt == '0);
        stat.emit_final = (cnt_reg == CNT_W'(1));
    end

    always_comb
    begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        fs_next         = fs_reg;
        ptr_next        = ptr_reg;
        in_frame_next   = in_frame_reg;
        start_byte_next = start_byte_reg;
        out_limit_next  = out_limit_reg;
        want_next       = want_reg;
        cnt_next        = cnt_reg;
        len_next        = len_reg;
        chk_valid_next  = 1'b0;
        pend_next       = 1'b0;
        pend_last_next  = pend_last_reg;
        strobe_next     = 1'b0;
        out_byte_next   = out_byte_reg;
        last_next       = last_reg;
        status_next     = status_reg;

        if (cfg_write)
        begin
            if (cfg_index == REG_START_BYTE)
            begin
                start_byte_next = cfg_data;
            end
            else if (cfg_index == REG_OUT_LIMIT)
            begin
                out_limit_next = cfg_data[6:0];
            end
        end

        if (cmd.load_want)
        begin
            want_next = wanted_type;
        end
        if (cmd.set_fs)
        begin
            fs_next = tail_reg;
        end
        if (cmd.write_byte)
        begin
            tail_next = tail_inc;
        end
        if (cmd.set_in_frame)
        begin
            in_frame_next = 1'b1;
        end
        if (cmd.clr_in_frame)
        begin
            in_frame_next = 1'b0;
        end
        if (cmd.ptr_type)
        begin
            ptr_next = ring_next(fs_reg);
        end
        if (cmd.scan_init)
        begin
            ptr_next = head_reg;
            len_next = '0;
        end
        if (cmd.scan_step)
        begin
            if (ptr_reg != tail_reg)
            begin
                ptr_next       = ring_next(ptr_reg);
                chk_valid_next = 1'b1;
            end
            if (chk_valid_reg)
            begin
                len_next = len_reg + CNT_W'(1);
            end
        end
        if (cmd.match_setup)
        begin
            tail_next = fs_reg;
            cnt_next  = match_cnt;
        end
        if (cmd.pull_setup)
        begin
            ptr_next  = head_reg;
            head_next = ptr_reg;
            cnt_next  = pull_cnt;
        end
        if (cmd.emit_step)
        begin
            ptr_next       = ring_next(ptr_reg);
            cnt_next       = cnt_reg - CNT_W'(1);
            pend_next      = 1'b1;
            pend_last_next = (cnt_reg == CNT_W'(1));
        end

        if (pend_reg)
        begin
            strobe_next   = 1'b1;
            out_byte_next = rd_data_reg;
            last_next     = pend_last_reg;
            status_next   = ST_DATA;
        end
        else if (cmd.emit_status)
        begin
            strobe_next   = 1'b1;
            out_byte_next = 8'd0;
            last_next     = 1'b1;
            status_next   = cmd.status_code;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg       <= '0;
            tail_reg       <= '0;
            fs_reg         <= '0;
            ptr_reg        <= '0;
            in_frame_reg   <= 1'b0;
            start_byte_reg <= START_RESET;
            out_limit_reg  <= LIMIT_RESET;
            want_reg       <= '0;
            cnt_reg        <= '0;
            len_reg        <= '0;
            chk_valid_reg  <= 1'b0;
            pend_reg       <= 1'b0;
            pend_last_reg  <= 1'b0;
            strobe_reg     <= 1'b0;
            out_byte_reg   <= '0;
            last_reg       <= 1'b0;
            status_reg     <= ST_DATA;
        end
        else
        begin
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            fs_reg         <= fs_next;
            ptr_reg        <= ptr_next;
            in_frame_reg   <= in_frame_next;
            start_byte_reg <= start_byte_next;
            out_limit_reg  <= out_limit_next;
            want_reg       <= want_next;
            cnt_reg        <= cnt_next;
            len_reg        <= len_next;
            chk_valid_reg  <= chk_valid_next;
            pend_reg       <= pend_next;
            pend_last_reg  <= pend_last_next;
            strobe_reg     <= strobe_next;
            out_byte_reg   <= out_byte_next;
            last_reg       <= last_next;
            status_reg     <= status_next;
        end
    end

    assign result_strobe = strobe_reg;
    assign out_byte      = out_byte_reg;
    assign last          = last_reg;
    assign status        = status_reg;

endmodule

### src/fmrr_controller.sv
module fmrr_controller (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               operation,
    input  fmrr_pkg::dp_stat_t stat,
    output fmrr_pkg::dp_cmd_t  cmd,
    output logic               busy
);
    import fmrr_pkg::*;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (operation == OP_PULL)
                    begin
                        state_next = S_SCAN;
                    end
                    else if (stat.in_frame && !stat.full && stat.is_cr)
                    begin
                        state_next = S_TYPE_RD;
                    end
                end
            end
            S_TYPE_RD:
            begin
                state_next = S_TYPE_CHK;
            end
            S_TYPE_CHK:
            begin
                if (stat.type_match && !stat.match_zero)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                if (stat.found)
                begin
                    state_next = stat.pull_zero ? S_IDLE : S_EMIT;
                end
                else if (stat.exhausted)
                begin
                    state_next = S_IDLE;
                end
            end
            S_EMIT:
            begin
                if (stat.emit_final)
                begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load_want = 1'b1;
                    if (operation == OP_PULL)
                    begin
                        cmd.scan_init = 1'b1;
                    end
                    else if (!stat.in_frame)
                    begin
                        if (!stat.is_start)
                        begin
                            cmd.emit_status = 1'b1;
                            cmd.status_code = ST_DROPPED;
                        end
                        else
                        begin
                            cmd.set_fs = 1'b1;
                            if (stat.full)
                            begin
                                cmd.emit_status = 1'b1;
                                cmd.status_code = ST_OVERFLOW;
                            end
                            else
                            begin
                                cmd.write_byte   = 1'b1;
                                cmd.set_in_frame = 1'b1;
                            end
                        end
                    end
                    else if (stat.full)
                    begin
                        cmd.emit_status = 1'b1;
                        cmd.status_code = ST_OVERFLOW;
                    end
                    else
                    begin
                        cmd.write_byte = 1'b1;
                        if (stat.is_cr)
                        begin
                            cmd.clr_in_frame = 1'b1;
                            cmd.ptr_type     = 1'b1;
                        end
                    end
                end
            end
            S_TYPE_CHK:
            begin
                if (stat.type_match)
                begin
                    cmd.match_setup = 1'b1;
                end
            end
            S_SCAN:
            begin
                if (stat.found)
                begin
                    cmd.pull_setup = 1'b1;
                end
                else if (stat.exhausted)
                begin
                    cmd.emit_status = 1'b1;
                    cmd.status_code = ST_EMPTY;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_EMIT:
            begin
                cmd.emit_step = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

### src/framed_message_ring_receiver.sv
// Channel   Transfer condition        Signals
// command   start && !busy            operation, in_byte, wanted_type
// config    cfg_valid && cfg_ready    cfg_index, cfg_data
// result    result_strobe             out_byte, last, status
//
// A byte that closes no frame is taken in S_IDLE; any status result appears the next cycle.
// A closing carriage return steps S_TYPE_RD, S_TYPE_CHK, then S_EMIT and S_FLUSH on a match.
// A pull walks the ring one byte a cycle from the oldest byte to the first carriage return
// through the single ring read port, then emits its bytes in S_EMIT and S_FLUSH.
// Reset clears pointers and frame state and presets config; ring contents stay undefined.
// Results cannot be stalled, and config transactions are always ready.
`include "framed_message_ring_receiver_defines.svh"

module framed_message_ring_receiver (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           operation,
    input  logic [7:0]                     in_byte,
    input  logic [7:0]                     wanted_type,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [fmrr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                     cfg_data,
    output logic                           result_strobe,
    output logic [7:0]                     out_byte,
    output logic                           last,
    output logic [1:0]                     status
);
    import fmrr_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic     cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    fmrr_controller u_controller (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (operation),
        .stat      (stat),
        .cmd       (cmd),
        .busy      (busy)
    );

    fmrr_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .in_byte       (in_byte),
        .wanted_type   (wanted_type),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .result_strobe (result_strobe),
        .out_byte      (out_byte),
        .last          (last),
        .status        (status)
    );

    `FMRR_ASSERT_SAME(a_status_is_last, result_strobe && (status != ST_DATA), last)
    `FMRR_ASSERT_NEXT(a_pull_goes_busy, start && !busy && (operation == OP_PULL), busy)
    `FMRR_ASSERT_NEXT(a_status_shown, cmd.emit_status, result_strobe && (status != ST_DATA))

endmodule

### bench/tb_framed_message_ring_receiver.sv
module tb_framed_message_ring_receiver;

    import fmrr_pkg::*;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 100;
    localparam logic [7:0] EQ_TYPE   = 8'h3D;
    localparam logic [7:0] BANG_TYPE = 8'h21;

    typedef struct {
        logic [7:0] data;
        logic       last;
        status_t    code;
    } rx_item_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic                 operation;
    logic [7:0]           in_byte;
    logic [7:0]           wanted_type;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [7:0]           cfg_data;
    logic                 result_strobe;
    logic [7:0]           out_byte;
    logic                 last;
    logic [1:0]           status;

    logic [7:0] ring_mem [RING_DEPTH];
    ptr_t       head_ptr;
    ptr_t       tail_ptr;
    ptr_t       frame_ptr;
    logic       frame_open;
    logic [7:0] start_reg;
    logic [6:0] limit_reg;

    rx_item_t pending_rx[$];
    rx_item_t oldest_rx;

    int gap_pct;
    int err_count;
    int cycle_count;
    int cmd_count;
    int pull_count;
    int cfg_count;
    int rx_count;
    int dropped_seen;
    int overflow_seen;
    int empty_seen;

    framed_message_ring_receiver u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .operation     (operation),
        .in_byte       (in_byte),
        .wanted_type   (wanted_type),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .result_strobe (result_strobe),
        .out_byte      (out_byte),
        .last          (last),
        .status        (status)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_strobe)
        begin
            rx_count++;
            case (status_t'(status))
                ST_DROPPED:  dropped_seen++;
                ST_OVERFLOW: overflow_seen++;
                ST_EMPTY:    empty_seen++;
                default:     ;
            endcase
            if (pending_rx.size() == 0)
            begin
                $error("unexpected result: out_byte %0h last %0b status %0d",
                       out_byte, last, status);
                err_count++;
            end
            else
            begin
                oldest_rx = pending_rx.pop_front();
                if (out_byte !== oldest_rx.data)
                begin
                    $error("out_byte: expected %0h, got %0h", oldest_rx.data, out_byte);
                    err_count++;
                end
                if (last !== oldest_rx.last)
                begin
                    $error("last: expected %0b, got %0b", oldest_rx.last, last);
                    err_count++;
                end
                if (status !== oldest_rx.code)
                begin
                    $error("status: expected %0d, got %0d", oldest_rx.code, status);
                    err_count++;
                end
            end
        end
    end

    function automatic int ring_used();
        return int'(ptr_t'(tail_ptr - head_ptr));
    endfunction

    function automatic int open_frame_len();
        return int'(ptr_t'(tail_ptr - frame_ptr));
    endfunction

    function automatic int emit_cap();
        int cap;
        cap = (limit_reg == 0) ? 0 : int'(limit_reg) - 1;
        return (cap > MAX_RESULTS) ? MAX_RESULTS : cap;
    endfunction

    function automatic logic [7:0] rand_payload();
        logic [7:0] b;
        b = 8'($urandom_range(255));
        return (b == CR_BYTE) ? ~b : b;
    endfunction

    function automatic logic [7:0] pick_want(input logic [7:0] frame_type);
        case ($urandom_range(3))
            0:       return EQ_TYPE;
            1:       return BANG_TYPE;
            2:       return frame_type;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic push_status(input status_t code);
        rx_item_t item;
        begin
            item = '{8'h00, 1'b1, code};
            pending_rx.push_back(item);
        end
    endtask

    task automatic push_burst(ref rx_item_t burst[$]);
        begin
            if (burst.size() > 0)
                burst[burst.size() - 1].last = 1'b1;
            foreach (burst[k])
                pending_rx.push_back(burst[k]);
        end
    endtask

    task automatic ring_pull_frame();
        rx_item_t   burst[$];
        rx_item_t   item;
        ptr_t       idx;
        logic [7:0] c;
        logic       found;
        begin
            idx = head_ptr;
            found = 1'b0;
            while (idx != tail_ptr && !found)
            begin
                c = ring_mem[idx];
                if (burst.size() < emit_cap())
                begin
                    item = '{c, 1'b0, ST_DATA};
                    burst.push_back(item);
                end
                idx = ptr_t'(idx + 1);
                if (c == CR_BYTE)
                begin
                    head_ptr = idx;
                    found = 1'b1;
                end
            end
            if (found)
                push_burst(burst);
            else
                push_status(ST_EMPTY);
        end
    endtask

    task automatic ring_accept_byte(input logic [7:0] b, input logic [7:0] want);
        rx_item_t   burst[$];
        rx_item_t   item;
        ptr_t       next_tail;
        ptr_t       idx;
        logic [7:0] c;
        begin
            next_tail = ptr_t'(tail_ptr + 1);
            if (!frame_open)
            begin
                if (b != start_reg)
                    push_status(ST_DROPPED);
                else
                begin
                    frame_ptr = tail_ptr;
                    if (next_tail == head_ptr)
                        push_status(ST_OVERFLOW);
                    else
                    begin
                        ring_mem[tail_ptr] = b;
                        tail_ptr = next_tail;
                        frame_open = 1'b1;
                    end
                end
            end
            else if (next_tail == head_ptr)
                push_status(ST_OVERFLOW);
            else
            begin
                ring_mem[tail_ptr] = b;
                tail_ptr = next_tail;
                if (b == CR_BYTE)
                begin
                    frame_open = 1'b0;
                    idx = ptr_t'(frame_ptr + 1);
                    if (ring_mem[idx] == want)
                    begin
                        while (idx != tail_ptr)
                        begin
                            c = ring_mem[idx];
                            idx = ptr_t'(idx + 1);
                            if (idx != tail_ptr && burst.size() < emit_cap())
                            begin
                                item = '{c, 1'b0, ST_DATA};
                                burst.push_back(item);
                            end
                        end
                        tail_ptr = frame_ptr;
                        push_burst(burst);
                    end
                end
            end
        end
    endtask

    task automatic send_cmd(input op_t op, input logic [7:0] b, input logic [7:0] want);
        begin
            while ($urandom_range(99) < gap_pct)
            begin
                start <= 1'b0;
                @(posedge clk);
            end
            start       <= 1'b1;
            operation   <= op;
            in_byte     <= b;
            wanted_type <= want;
            @(posedge clk);
            while (busy)
                @(posedge clk);
            cmd_count++;
            if (op == OP_PULL)
            begin
                pull_count++;
                ring_pull_frame();
            end
            else
                ring_accept_byte(b, want);
        end
    endtask

    task automatic send_pull();
        begin
            send_cmd(OP_PULL, 8'($urandom_range(255)), 8'($urandom_range(255)));
        end
    endtask

    task automatic send_guarded(input logic [7:0] b, input logic [7:0] want);
        begin
            if (frame_open && open_frame_len() >= 50)
                send_cmd(OP_BYTE, CR_BYTE, want);
            else
                send_cmd(OP_BYTE, b, want);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
        begin
            start <= 1'b0;
            while (pending_rx.size() != 0)
                @(posedge clk);
            repeat (SETTLE_CYCLES)
                @(posedge clk);
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= value;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            cfg_valid <= 1'b0;
            cfg_count++;
            if (idx == REG_START_BYTE)
                start_reg = value;
            else if (idx == REG_OUT_LIMIT)
                limit_reg = value[6:0];
        end
    endtask

    task automatic set_config(input logic [7:0] start_value, input logic [6:0] limit_value);
        begin
            write_reg(REG_START_BYTE, start_value);
            write_reg(REG_OUT_LIMIT, {1'b0, limit_value});
        end
    endtask

    task automatic send_filler_frame(input int len);
        begin
            send_cmd(OP_BYTE, start_reg, 8'($urandom_range(255)));
            if (len >= 3)
                send_cmd(OP_BYTE, BANG_TYPE, 8'($urandom_range(255)));
            if (len >= 4)
                send_cmd(OP_BYTE, rand_payload(), 8'($urandom_range(255)));
            send_cmd(OP_BYTE, CR_BYTE, EQ_TYPE);
        end
    endtask

    task automatic send_random_frame();
        logic [7:0] frame_type;
        int         len;
        begin
            case ($urandom_range(3))
                0:       frame_type = EQ_TYPE;
                1:       frame_type = BANG_TYPE;
                default: frame_type = 8'($urandom_range(255));
            endcase
            len = ($urandom_range(11) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
            send_guarded(start_reg, 8'($urandom_range(255)));
            send_guarded(frame_type, 8'($urandom_range(255)));
            repeat (len)
                send_guarded(rand_payload(), 8'($urandom_range(255)));
            send_cmd(OP_BYTE, CR_BYTE, pick_want(frame_type));
        end
    endtask

    task automatic test_stray_and_empty();
        begin
            send_cmd(OP_BYTE, 8'h00, 8'hFF);
            send_cmd(OP_BYTE, 8'hFF, 8'h00);
            send_cmd(OP_PULL, 8'h00, 8'h00);
        end
    endtask

    task automatic test_matched_frame();
        begin
            send_cmd(OP_BYTE, start_reg, 8'h00);
            send_cmd(OP_BYTE, EQ_TYPE, 8'h00);
            send_cmd(OP_BYTE, 8'h00, 8'hFF);
            send_cmd(OP_BYTE, 8'hFF, 8'h00);
            send_cmd(OP_BYTE, CR_BYTE, EQ_TYPE);
        end
    endtask

    task automatic test_queued_frame_pull();
        begin
            send_cmd(OP_BYTE, start_reg, BANG_TYPE);
            send_cmd(OP_BYTE, BANG_TYPE, EQ_TYPE);
            send_cmd(OP_BYTE, 8'h55, EQ_TYPE);
            send_cmd(OP_BYTE, CR_BYTE, EQ_TYPE);
            send_cmd(OP_PULL, 8'hFF, 8'hFF);
        end
    endtask

    task automatic test_frame_edge_cases();
        begin
            send_cmd(OP_BYTE, start_reg, CR_BYTE);
            send_cmd(OP_BYTE, CR_BYTE, CR_BYTE);
            send_cmd(OP_BYTE, start_reg, EQ_TYPE);
            send_cmd(OP_BYTE, EQ_TYPE, EQ_TYPE);
            send_cmd(OP_PULL, 8'h00, 8'h00);
            send_cmd(OP_BYTE, CR_BYTE, EQ_TYPE);
        end
    endtask

    task automatic test_out_limit();
        begin
            write_reg(REG_OUT_LIMIT, 8'd2);
            send_cmd(OP_BYTE, start_reg, 8'h00);
            send_cmd(OP_BYTE, BANG_TYPE, 8'h00);
            send_cmd(OP_BYTE, CR_BYTE, EQ_TYPE);
            send_cmd(OP_BYTE, start_reg, 8'h00);
            send_cmd(OP_BYTE, EQ_TYPE, 8'h00);
            send_cmd(OP_BYTE, 8'h01, 8'h00);
            send_cmd(OP_BYTE, CR_BYTE, EQ_TYPE);
            send_cmd(OP_PULL, 8'h00, 8'h00);
            write_reg(REG_OUT_LIMIT, 8'd1);
            send_cmd(OP_BYTE, start_reg, 8'h00);
            send_cmd(OP_BYTE, BANG_TYPE, 8'h00);
            send_cmd(OP_BYTE, CR_BYTE, BANG_TYPE);
            send_cmd(OP_BYTE, start_reg, 8'h00);
            send_cmd(OP_BYTE, CR_BYTE, BANG_TYPE);
            write_reg(REG_OUT_LIMIT, 8'd0);
            send_cmd(OP_PULL, 8'h00, 8'h00);
            send_cmd(OP_PULL, 8'h00, 8'h00);
        end
    endtask

    task automatic test_start_byte();
        begin
            set_config(8'h00, 7'd64);
            send_cmd(OP_BYTE, 8'h00, 8'h00);
            send_cmd(OP_BYTE, EQ_TYPE, 8'h00);
            send_cmd(OP_BYTE, CR_BYTE, EQ_TYPE);
            send_cmd(OP_BYTE, START_RESET, 8'h00);
            write_reg(REG_START_BYTE, 8'hFF);
            send_cmd(OP_BYTE, 8'hFF, 8'h00);
            send_cmd(OP_BYTE, BANG_TYPE, 8'h00);
            send_cmd(OP_BYTE, 8'h7F, 8'h00);
            send_cmd(OP_BYTE, CR_BYTE, BANG_TYPE);
        end
    endtask

    task automatic test_ring_overflow();
        int free_slots;
        begin
            gap_pct = 0;
            set_config(START_RESET, 7'd127);
            while (ring_used() < 30)
            begin
                send_cmd(OP_BYTE, start_reg, 8'($urandom_range(255)));
                send_cmd(OP_BYTE, BANG_TYPE, 8'($urandom_range(255)));
                repeat (5)
                    send_cmd(OP_BYTE, rand_payload(), 8'($urandom_range(255)));
                send_cmd(OP_BYTE, CR_BYTE, EQ_TYPE);
            end
            send_cmd(OP_BYTE, start_reg, 8'($urandom_range(255)));
            send_cmd(OP_BYTE, BANG_TYPE, 8'($urandom_range(255)));
            while (ring_used() < RING_DEPTH - 1)
                send_cmd(OP_BYTE, rand_payload(), 8'($urandom_range(255)));
            repeat (3)
                send_cmd(OP_BYTE, rand_payload(), 8'($urandom_range(255)));
            send_cmd(OP_BYTE, CR_BYTE, EQ_TYPE);
            send_pull();
            send_cmd(OP_BYTE, CR_BYTE, EQ_TYPE);
            while (ring_used() < RING_DEPTH - 1)
            begin
                free_slots = RING_DEPTH - 1 - ring_used();
                send_filler_frame((free_slots >= 5) ? 3 : free_slots);
            end
            send_cmd(OP_BYTE, start_reg, 8'($urandom_range(255)));
            send_cmd(OP_BYTE, 8'h00, 8'($urandom_range(255)));
            while (ring_used() != 0)
                send_pull();
            send_pull();
            gap_pct = 29;
        end
    endtask

    task automatic test_random_traffic();
        logic [7:0] start_values [6];
        logic [6:0] limit_values [6];
        int         phase_end;
        int         pick;
        begin
            start_values = '{START_RESET, 8'h00, 8'hFF, CR_BYTE, EQ_TYPE, 8'h00};
            limit_values = '{7'd64, 7'd2, 7'd127, 7'd1, 7'd0, 7'd0};
            start_values[5] = 8'($urandom_range(255));
            limit_values[5] = 7'($urandom_range(127));
            for (int p = 0; p < 6; p++)
            begin
                set_config(start_values[p], limit_values[p]);
                phase_end = cmd_count + 2;
                while (cmd_count < phase_end)
                begin
                    pick = $urandom_range(99);
                    if (pick < 50)
                        send_random_frame();
                    else if (pick < 72)
                        send_pull();
                    else if (pick < 88)
                        send_guarded(8'($urandom_range(255)), 8'($urandom_range(255)));
                    else
                    begin
                        send_guarded(start_reg, 8'($urandom_range(255)));
                        repeat ($urandom_range(1, 4))
                            send_guarded(rand_payload(), 8'($urandom_range(255)));
                    end
                end
            end
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        operation   = OP_BYTE;
        in_byte     = 8'h00;
        wanted_type = 8'h00;
        cfg_valid   = 1'b0;
        cfg_index   = REG_START_BYTE;
        cfg_data    = 8'h00;
        head_ptr    = '0;
        tail_ptr    = '0;
        frame_ptr   = '0;
        frame_open  = 1'b0;
        start_reg   = START_RESET;
        limit_reg   = LIMIT_RESET;
        gap_pct     = 29;
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;

        test_stray_and_empty();
        test_matched_frame();
        test_queued_frame_pull();
        test_frame_edge_cases();
        test_out_limit();
        test_start_byte();
        test_ring_overflow();
        test_random_traffic();

        start <= 1'b0;
        while (pending_rx.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        $display("Sent %0d commands including %0d pulls, with %0d register writes.",
                 cmd_count, pull_count, cfg_count);
        $display("Checked %0d results: %0d stray drops, %0d overflow drops, %0d empty pulls.",
                 rx_count, dropped_seen, overflow_seen, empty_seen);
        if (err_count == 0 && pending_rx.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
